// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset-qualified
`define CHK_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset-qualified
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/bfs_pkg.sv
// shared types and constants for the breadth-first search block
// no dependencies
package bfs_pkg;

  localparam int NODE_W            = 6;
  localparam int DEF_VERTEX_COUNT  = 64;
  localparam int DEF_EDGE_CAPACITY = 256;

  // controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic list_rd_add;
    logic add_commit;
    logic init_search;
    logic take_v;
    logic load_edges;
    logic edge_step;
    logic emit;
  } bfs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_search;
    logic add_ok;
    logic start_ok;
    logic is_goal;
    logic has_edges;
    logic edge_end;
    logic out_free;
    logic out_is_last;
  } bfs_stat_t;

endpackage

// File: rtl/core/bfs_graph_search_top.sv
// top level of the breadth-first search block
// depends on bfs_pkg, bfs_ctrl and bfs_dp
//
//  channel | direction | fields
//  in_     | input     | command, first_node, second_node
//  out_    | output    | visited_node, last, reached_goal
//
// add edge: after acceptance the start and write steps run before the next
//   transaction can be taken; only the start step runs when the edge is dropped
// search: dequeue, queue-wait and list-wait steps per vertex, edge and edge-wait
//   steps per walked edge, set by the registered reads of the queue, list and edge rams
// reset clears edge count, list valid bits, visited map and queue pointers
// a stalled result holds the walk in its emit step until it is taken
module bfs_graph_search_top
  import bfs_pkg::*;
#(
  parameter int VERTEX_COUNT  = DEF_VERTEX_COUNT,
  parameter int EDGE_CAPACITY = DEF_EDGE_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [NODE_W-1:0] in_first_node,
  input  logic [NODE_W-1:0] in_second_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_visited_node,
  output logic              out_last,
  output logic              out_reached_goal
);

  bfs_cmd_t  cmd;
  bfs_stat_t stat;

  // sequencer
  bfs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .stat, .cmd
  );

  // storage and result register
  bfs_dp #(
    .VERTEX_COUNT(VERTEX_COUNT), .EDGE_CAPACITY(EDGE_CAPACITY)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_command, .in_first_node, .in_second_node,
    .out_valid, .out_ready, .out_visited_node, .out_last, .out_reached_goal
  );

endmodule

// File: rtl/core/bfs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bfs_ctrl.sv
// sequencing state machine for edge insertion and search
// depends on bfs_pkg
module bfs_ctrl
  import bfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bfs_stat_t stat,
  output bfs_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_ADD_WR = 4'd2;
  localparam logic [3:0] ST_DEQ    = 4'd3;
  localparam logic [3:0] ST_QWAIT  = 4'd4;
  localparam logic [3:0] ST_LWAIT  = 4'd5;
  localparam logic [3:0] ST_EDGE   = 4'd6;
  localparam logic [3:0] ST_EWAIT  = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_START;
        end
      end
      ST_START: begin
        if (stat.is_search) begin
          if (stat.start_ok) begin
            cmd.init_search = 1'b1;
            state_nxt       = ST_DEQ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (stat.add_ok) begin
          cmd.list_rd_add = 1'b1;
          state_nxt       = ST_ADD_WR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD_WR: begin
        cmd.add_commit = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_DEQ: begin
        state_nxt = ST_QWAIT;
      end
      ST_QWAIT: begin
        cmd.take_v = 1'b1;
        state_nxt  = ST_LWAIT;
      end
      ST_LWAIT: begin
        if (stat.is_goal || !stat.has_edges) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.load_edges = 1'b1;
          state_nxt      = ST_EDGE;
        end
      end
      ST_EDGE: begin
        state_nxt = ST_EWAIT;
      end
      ST_EWAIT: begin
        cmd.edge_step = 1'b1;
        state_nxt     = stat.edge_end ? ST_EMIT : ST_EDGE;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.out_is_last ? ST_IDLE : ST_DEQ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/bfs_dp.sv
// datapath: edge store, list heads and tails, visited map, queue, result register
// depends on bfs_pkg and bfs_ram
module bfs_dp
  import bfs_pkg::*;
#(
  parameter int VERTEX_COUNT  = DEF_VERTEX_COUNT,
  parameter int EDGE_CAPACITY = DEF_EDGE_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bfs_cmd_t          cmd,
  output bfs_stat_t         stat,
  input  logic              in_command,
  input  logic [NODE_W-1:0] in_first_node,
  input  logic [NODE_W-1:0] in_second_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_visited_node,
  output logic              out_last,
  output logic              out_reached_goal
);

  localparam int VW  = $clog2(VERTEX_COUNT);
  localparam int EAW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int CW  = $clog2(EDGE_CAPACITY + 1);

  // latched transaction
  logic              cmd_r;
  logic [NODE_W-1:0] a_r, b_r;

  logic [CW-1:0]       count_r;
  logic [VERTEX_COUNT-1:0] list_valid_r;
  logic [VERTEX_COUNT-1:0] visited_r;
  logic [VW:0]         head_r, tail_r;
  logic [VW-1:0]       v_r;
  logic [EAW-1:0]      e_r, tail_e_r;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_node_r;
  logic              out_last_r, out_goal_r;

  // ram signals
  logic              list_we;
  logic [VW-1:0]     list_waddr, list_raddr;
  logic [2*EAW-1:0]  list_wdata, list_rdata;
  logic [EAW-1:0]    list_head, list_tail;
  logic              link_we;
  logic [EAW-1:0]    link_rdata;
  logic              tgt_we;
  logic [VW-1:0]     tgt_rdata;
  logic              q_we;
  logic [VW-1:0]     q_waddr, q_wdata, q_rdata;
  logic [EAW-1:0]    new_e;
  logic              a_in, b_in, enq;
  logic              v_listed, v_goal, q_empty;

  assign a_in      = ({1'b0, a_r} < (NODE_W+1)'(VERTEX_COUNT));
  assign b_in      = ({1'b0, b_r} < (NODE_W+1)'(VERTEX_COUNT));
  assign new_e     = count_r[EAW-1:0];
  assign list_head = list_rdata[2*EAW-1:EAW];
  assign list_tail = list_rdata[EAW-1:0];
  assign v_listed  = list_valid_r[v_r];
  assign v_goal    = (NODE_W'(v_r) == b_r);
  assign q_empty   = (head_r == tail_r);
  assign enq       = cmd.edge_step && !visited_r[tgt_rdata];

  // status to controller
  always_comb begin
    stat.is_search   = cmd_r;
    stat.add_ok      = a_in && b_in && (count_r < CW'(EDGE_CAPACITY));
    stat.start_ok    = a_in;
    stat.is_goal     = v_goal;
    stat.has_edges   = v_listed;
    stat.edge_end    = (e_r == tail_e_r);
    stat.out_free    = !out_valid_r || out_ready;
    stat.out_is_last = v_goal || q_empty;
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_command;
      a_r   <= in_first_node;
      b_r   <= in_second_node;
    end
  end

  // list ram: {head, tail} per vertex
  assign list_raddr = cmd.list_rd_add ? a_r[VW-1:0] : q_rdata;
  assign list_we    = cmd.add_commit;
  assign list_waddr = a_r[VW-1:0];
  assign list_wdata = {(list_valid_r[a_r[VW-1:0]] ? list_head : new_e), new_e};

  // edge store writes
  assign link_we = cmd.add_commit && list_valid_r[a_r[VW-1:0]];
  assign tgt_we  = cmd.add_commit;

  // queue writes: start vertex on init, new neighbour during walk
  assign q_we    = cmd.init_search || enq;
  assign q_waddr = cmd.init_search ? '0 : tail_r[VW-1:0];
  assign q_wdata = cmd.init_search ? a_r[VW-1:0] : tgt_rdata;

  bfs_ram #(.WIDTH(2*EAW), .DEPTH(VERTEX_COUNT)) u_list (
    .clk, .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_rdata)
  );

  bfs_ram #(.WIDTH(EAW), .DEPTH(EDGE_CAPACITY)) u_link (
    .clk, .we(link_we), .waddr(list_tail), .wdata(new_e),
    .raddr(e_r), .rdata(link_rdata)
  );

  bfs_ram #(.WIDTH(VW), .DEPTH(EDGE_CAPACITY)) u_tgt (
    .clk, .we(tgt_we), .waddr(new_e), .wdata(b_r[VW-1:0]),
    .raddr(e_r), .rdata(tgt_rdata)
  );

  bfs_ram #(.WIDTH(VW), .DEPTH(VERTEX_COUNT)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[VW-1:0]), .rdata(q_rdata)
  );

  // edge count and list valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      list_valid_r <= '0;
    end else if (cmd.add_commit) begin
      count_r                   <= count_r + 1'b1;
      list_valid_r[a_r[VW-1:0]] <= 1'b1;
    end
  end

  // visited map and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
    end else if (cmd.init_search) begin
      visited_r              <= '0;
      visited_r[a_r[VW-1:0]] <= 1'b1;
      head_r                 <= '0;
      tail_r                 <= (VW+1)'(1);
    end else begin
      if (cmd.take_v) begin
        head_r <= head_r + 1'b1;
      end
      if (enq) begin
        visited_r[tgt_rdata] <= 1'b1;
        tail_r               <= tail_r + 1'b1;
      end
    end
  end

  // current vertex and edge walk
  always_ff @(posedge clk) begin
    if (cmd.take_v) begin
      v_r <= q_rdata;
    end
    if (cmd.load_edges) begin
      e_r      <= list_head;
      tail_e_r <= list_tail;
    end else if (cmd.edge_step) begin
      e_r <= link_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_node_r <= NODE_W'(v_r);
      out_last_r <= v_goal || q_empty;
      out_goal_r <= v_goal;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visited_node = out_node_r;
  assign out_last         = out_last_r;
  assign out_reached_goal = out_goal_r;

endmodule

// File: rtl/core/bfs_checker.sv
// port-level checks for the breadth-first search block, bound to the top level
// depends on bfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module bfs_checker
  import bfs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic [NODE_W-1:0] in_first_node,
  input logic [NODE_W-1:0] in_second_node,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NODE_W-1:0] out_visited_node,
  input logic              out_last,
  input logic              out_reached_goal
);

  // a stalled result stays valid and keeps its node and last flag
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_visited_node) && $stable(out_last))

  // finding the goal ends the search
  `CHK_SAME(a_goal_last, clk, rst_n, out_valid && out_reached_goal, out_last)

  // more results to come: no new transaction taken
  `CHK_SAME(a_busy_mid, clk, rst_n, out_valid && !out_last, !in_ready)

  // any accepted transaction occupies the block the next cycle
  `CHK_NEXT(a_busy_after, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind bfs_graph_search_top bfs_checker u_bfs_checker (.*);
